FILE: rtl/core/prdft_pkg.sv
// Package for the running DFT accumulator: sizes, command codes, state type,
// and the quarter-wave sine table.
// Uses nothing else.
package prdft_pkg;
    localparam int MAX_BINS    = 64;
    localparam int TABLE_BITS  = 10;
    localparam int SAMPLE_BITS = 16;
    localparam int ACC_BITS    = 48;
    localparam int NCOMP       = 6;
    localparam int BIN_W       = 6;
    localparam int QUARTER     = 1 << (TABLE_BITS - 2);
    localparam int AMP_BITS    = 16;
    localparam int PROD_BITS   = SAMPLE_BITS + AMP_BITS;
    localparam int CLR_W       = $clog2(MAX_BINS);

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] REG_START   = 2'd0;
    localparam logic [1:0] REG_SPACING = 2'd1;
    localparam logic [1:0] REG_NBINS   = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_FREQ, ST_PHASE, ST_RUN, ST_READ
    } t_state;

    typedef struct packed {
        logic en;
        logic clr;
        logic [CLR_W-1:0] addr;
    } t_lane_ctl;

    // Quarter-wave table built at elaboration from the Taylor series in Q2.30.
    function automatic logic [AMP_BITS-1:0] qsin(input int k);
        logic [63:0] x, x2, t, e;
        logic signed [63:0] s;
        int n;
        x = (64'(k) * 64'd1686629713) / 64'(QUARTER);
        x2 = (x * x) >> 30;
        t = x;
        s = $signed(x);
        for (n = 1; n <= 8; n++) begin
            t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) s = s - $signed(t);
            else s = s + $signed(t);
        end
        if (s < 0) s = 0;
        e = (64'(s) + 64'd32768) >> 16;
        if (e > 64'd16384) e = 64'd16384;
        return e[AMP_BITS-1:0];
    endfunction

    function automatic logic [QUARTER*AMP_BITS-1:0] qsin_table();
        logic [QUARTER*AMP_BITS-1:0] tab;
        for (int k = 0; k < QUARTER; k++) tab[k*AMP_BITS +: AMP_BITS] = qsin(k);
        return tab;
    endfunction

    localparam logic [QUARTER*AMP_BITS-1:0] QSIN_TAB = qsin_table();
    localparam logic [AMP_BITS-1:0] QSIN_TOP = qsin(QUARTER);

    function automatic logic signed [AMP_BITS:0] sin_at(input logic [TABLE_BITS-1:0] i);
        logic [TABLE_BITS-3:0] r, rm;
        logic [AMP_BITS-1:0] v;
        r = i[TABLE_BITS-3:0];
        rm = (TABLE_BITS-2)'(QUARTER - int'(r));
        case (i[TABLE_BITS-1:TABLE_BITS-2])
            2'd0, 2'd2: v = QSIN_TAB[int'(r)*AMP_BITS +: AMP_BITS];
            default: v = (r == '0) ? QSIN_TOP : QSIN_TAB[int'(rm)*AMP_BITS +: AMP_BITS];
        endcase
        if (i[TABLE_BITS-1]) return -$signed({1'b0, v});
        return $signed({1'b0, v});
    endfunction
endpackage

FILE: rtl/core/point_running_dft_accumulator.sv
// Top level of the running DFT accumulator: sequencer, phase path, six lanes
// and the read merge. Uses prdft_pkg and prdft_lane.
// After reset the block clears its store while busy is high. An accumulate
// runs one bin per cycle through the phase multiplier and each lane's
// read-modify-write of its sum memory. A read keeps busy high, and its
// result appears on o_valid for one cycle, the first cycle with busy low;
// the receiver cannot stall it. Configuration is taken only while busy is low.
module point_running_dft_accumulator import prdft_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_command,
    input  logic [31:0]        i_time_step,
    input  logic signed [SAMPLE_BITS-1:0] i_ex_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_ey_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_ez_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_hx_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_hy_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_hz_sample,
    input  logic [BIN_W-1:0]   i_read_bin,
    input  logic [2:0]         i_read_component,
    output logic               o_valid,
    output logic signed [ACC_BITS-1:0] o_real_sum,
    output logic signed [ACC_BITS-1:0] o_imag_sum,
    output logic [31:0]        o_bin_frequency,
    output logic [BIN_W-1:0]   o_read_index
);
    t_state r_state, n_state;
    logic [31:0] r_start, r_spacing, r_ts, r_freq, r_phase;
    logic [BIN_W-1:0] r_nbins, r_bin, r_rbin, r_pbin;
    logic [2:0] r_rcomp;
    logic r_pval;
    logic [TABLE_BITS-1:0] r_idx;
    logic r_ival, r_last;
    logic [BIN_W-1:0] r_ibin;
    logic [CLR_W-1:0] r_clr_cnt;
    logic [3:0] r_rdcnt;
    logic signed [SAMPLE_BITS-1:0] r_smp [NCOMP];
    logic signed [AMP_BITS:0] w_cos, w_sin;
    logic signed [ACC_BITS-1:0] w_re [NCOMP];
    logic signed [ACC_BITS-1:0] w_im [NCOMP];
    t_lane_ctl w_ctl;
    logic w_accept;

    assign busy = (r_state != ST_IDLE);
    assign o_cfg_ready = !busy;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0; r_spacing <= '0; r_nbins <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_START:   r_start <= i_cfg_data;
                REG_SPACING: r_spacing <= i_cfg_data;
                REG_NBINS:   r_nbins <= i_cfg_data[BIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr_cnt == CLR_W'(MAX_BINS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (w_accept) n_state = (i_command == CMD_READ) ? ST_READ : ST_FREQ;
            ST_FREQ:  if (r_bin == r_nbins) n_state = ST_RUN;
            ST_RUN:   if (!r_pval && !r_ival && !r_last) n_state = ST_IDLE;
            ST_READ:  if (r_rdcnt == 4'd3) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR; r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // stage 1: bin frequency; stage 2: phase, table index taken from it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pval <= 1'b0; r_ival <= 1'b0; r_last <= 1'b0; r_bin <= '0; r_rdcnt <= '0;
        end else begin
            r_last <= r_ival;
            if (w_accept) begin
                r_bin <= '0; r_rdcnt <= '0;
                r_ts <= i_time_step; r_rbin <= i_read_bin; r_rcomp <= i_read_component;
                r_smp[0] <= i_ex_sample; r_smp[1] <= i_ey_sample; r_smp[2] <= i_ez_sample;
                r_smp[3] <= i_hx_sample; r_smp[4] <= i_hy_sample; r_smp[5] <= i_hz_sample;
            end else if (r_state == ST_FREQ) begin
                r_bin <= r_bin + 1'b1;
            end
            if (r_state == ST_READ) r_rdcnt <= r_rdcnt + 1'b1;
            r_pval <= (r_state == ST_FREQ);
            r_pbin <= r_bin;
            r_freq <= r_start + 32'(r_bin * r_spacing);
            r_phase <= r_ts * r_freq;
            r_ival <= r_pval;
            r_ibin <= r_pbin;
        end
    end

    assign r_idx = r_phase[31 -: TABLE_BITS];
    assign w_cos = sin_at(r_idx + TABLE_BITS'(QUARTER));
    assign w_sin = sin_at(r_idx);
    assign w_ctl.en = r_ival;
    assign w_ctl.clr = (r_state == ST_CLEAR);
    assign w_ctl.addr = (r_state == ST_CLEAR) ? r_clr_cnt : r_ibin;

    genvar g;
    generate
        for (g = 0; g < NCOMP; g++) begin : g_lane
            prdft_lane u_lane (
                .i_clk(i_clk), .i_ctl(w_ctl), .i_sample(r_smp[g]),
                .i_cos(w_cos), .i_sin(w_sin), .i_rd_addr(r_rbin),
                .o_re(w_re[g]), .o_im(w_im[g])
            );
        end
    endgenerate

    // merge: pick the asked component; frequency recomputed from the read bin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= (r_state == ST_READ) && (r_rdcnt == 4'd3);
        o_real_sum <= (r_rcomp < 3'(NCOMP)) ? w_re[r_rcomp] : '0;
        o_imag_sum <= (r_rcomp < 3'(NCOMP)) ? w_im[r_rcomp] : '0;
        o_bin_frequency <= r_start + 32'(r_rbin * r_spacing);
        o_read_index <= r_rbin;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> !$past(o_valid))
        else $error("result strobe longer than one cycle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_command == CMD_ACCUM) |=> r_state == ST_FREQ)
        else $error("accumulate not started");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_ival |-> busy)
        else $error("lane update while idle");
endmodule

FILE: rtl/core/prdft_lane.sv
// One component lane: memory of real/imag sums per bin, multiply and
// saturating update. Uses prdft_pkg.
module prdft_lane import prdft_pkg::*; (
    input  logic                       i_clk,
    input  t_lane_ctl                  i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [AMP_BITS:0]   i_cos,
    input  logic signed [AMP_BITS:0]   i_sin,
    input  logic [CLR_W-1:0]           i_rd_addr,
    output logic signed [ACC_BITS-1:0] o_re,
    output logic signed [ACC_BITS-1:0] o_im
);
    logic signed [ACC_BITS-1:0] r_mem_re [MAX_BINS];
    logic signed [ACC_BITS-1:0] r_mem_im [MAX_BINS];
    logic signed [PROD_BITS:0] r_pre, r_pim;
    logic signed [ACC_BITS-1:0] r_rd_re, r_rd_im;
    logic r_en, r_clr;
    logic [CLR_W-1:0] r_addr;
    logic signed [ACC_BITS-1:0] n_re, n_im;

    function automatic logic signed [ACC_BITS-1:0] sat(
        input logic signed [ACC_BITS-1:0] a, input logic signed [PROD_BITS:0] b);
        logic signed [ACC_BITS:0] s;
        s = {a[ACC_BITS-1], a} + (ACC_BITS+1)'(b);
        if (s[ACC_BITS] != s[ACC_BITS-1])
            return s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
        return s[ACC_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        r_pre   <= (PROD_BITS+1)'(i_sample) * (PROD_BITS+1)'(i_cos);
        r_pim   <= -((PROD_BITS+1)'(i_sample) * (PROD_BITS+1)'(i_sin));
        r_en    <= i_ctl.en;
        r_clr   <= i_ctl.clr;
        r_addr  <= i_ctl.addr;
        r_rd_re <= r_mem_re[i_ctl.addr];
        r_rd_im <= r_mem_im[i_ctl.addr];
        o_re    <= r_mem_re[i_rd_addr];
        o_im    <= r_mem_im[i_rd_addr];
    end

    assign n_re = r_clr ? '0 : sat(r_rd_re, r_pre);
    assign n_im = r_clr ? '0 : sat(r_rd_im, r_pim);

    always_ff @(posedge i_clk) begin
        if (r_en || r_clr) begin
            r_mem_re[r_addr] <= n_re;
            r_mem_im[r_addr] <= n_im;
        end
    end
endmodule

FILE: tb/sv/point_running_dft_accumulator_tb.sv
// Self-checking testbench for point_running_dft_accumulator: directed table, then random
// accumulate/read traffic across several register settings, checked against a predictor.
// Depends on prdft_pkg and the RTL of point_running_dft_accumulator.
module point_running_dft_accumulator_tb;
    import prdft_pkg::*;

    typedef struct {
        logic        cmd;
        logic [31:0] step;
        logic signed [15:0] smp [6];
        logic [5:0]  bin;
        logic [2:0]  comp;
        bit          lit;
        longint      lit_re;
        longint      lit_im;
    } t_item;

    typedef struct {
        logic [47:0] re;
        logic [47:0] im;
        logic [31:0] freq;
        logic [5:0]  idx;
    } t_readout;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = REG_START;
    logic [31:0] i_cfg_data = 0;
    logic i_command = CMD_ACCUM;
    logic [31:0] i_time_step = 0;
    logic signed [15:0] i_ex_sample = 0, i_ey_sample = 0, i_ez_sample = 0;
    logic signed [15:0] i_hx_sample = 0, i_hy_sample = 0, i_hz_sample = 0;
    logic [5:0] i_read_bin = 0;
    logic [2:0] i_read_component = 0;
    logic o_valid;
    logic signed [47:0] o_real_sum, o_imag_sum;
    logic [31:0] o_bin_frequency;
    logic [5:0] o_read_index;

    point_running_dft_accumulator i_dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    int unsigned qwave [257];
    longint sums [64][6][2];
    logic [31:0] frq_start, frq_space;
    logic [5:0] nbins_m1;
    t_readout readout_q[$];
    int errors = 0;
    int cycles = 0;
    int n_acc = 0, n_rd = 0;

    function automatic void build_wave();
        longint unsigned x, x2, t, e;
        longint s;
        for (int k = 0; k <= 256; k++) begin
            x = (longint'(k) * 64'd1686629713) / 256;
            x2 = (x * x) >> 30;
            t = x;
            s = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                t = ((t * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2) s -= longint'(t);
                else s += longint'(t);
            end
            if (s < 0) s = 0;
            e = (longint'(s) + 32768) >> 16;
            if (e > 16384) e = 16384;
            qwave[k] = 32'(e);
        end
    endfunction

    function automatic longint wave_sin(logic [9:0] i);
        logic [7:0] r;
        r = i[7:0];
        case (i[9:8])
            2'd0: return qwave[r];
            2'd1: return qwave[256 - r];
            2'd2: return -longint'(qwave[r]);
            default: return -longint'(qwave[256 - r]);
        endcase
    endfunction

    function automatic longint sat48(longint a, longint b);
        longint hi, lo;
        hi = (64'sd1 <<< 47) - 1;
        lo = -hi - 1;
        if (b > 0 && a > hi - b) return hi;
        if (b < 0 && a < lo - b) return lo;
        return a + b;
    endfunction

    function automatic void dft_predict(t_item it);
        logic [31:0] f, ph;
        logic [9:0] ix;
        longint sv, cv;
        t_readout r;
        if (it.cmd == CMD_ACCUM) begin
            for (int b = 0; b <= nbins_m1; b++) begin
                f = frq_start + 32'(b) * frq_space;
                ph = it.step * f;
                ix = ph[31:22];
                sv = wave_sin(ix);
                cv = wave_sin(ix + 10'd256);
                for (int c = 0; c < 6; c++) begin
                    sums[b][c][0] = sat48(sums[b][c][0], longint'(it.smp[c]) * cv);
                    sums[b][c][1] = sat48(sums[b][c][1], -(longint'(it.smp[c]) * sv));
                end
            end
            n_acc++;
            return;
        end
        r.re = 0;
        r.im = 0;
        if (it.comp < 6) begin
            r.re = sums[it.bin][it.comp][0][47:0];
            r.im = sums[it.bin][it.comp][1][47:0];
        end
        if (it.lit) begin
            r.re = it.lit_re[47:0];
            r.im = it.lit_im[47:0];
        end
        r.freq = frq_start + 32'(it.bin) * frq_space;
        r.idx = it.bin;
        readout_q = {readout_q, r};
        n_rd++;
    endfunction

    always @(posedge i_clk) begin
        t_readout r;
        if (i_rst_n && o_valid) begin
            if (readout_q.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                r = readout_q.pop_front();
                if (o_real_sum !== r.re) begin
                    $error("real_sum exp %h got %h", r.re, o_real_sum);
                    errors++;
                end
                if (o_imag_sum !== r.im) begin
                    $error("imag_sum exp %h got %h", r.im, o_imag_sum);
                    errors++;
                end
                if (o_bin_frequency !== r.freq) begin
                    $error("bin_frequency exp %h got %h", r.freq, o_bin_frequency);
                    errors++;
                end
                if (o_read_index !== r.idx) begin
                    $error("read_index exp %0d got %0d", r.idx, o_read_index);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("point_running_dft_accumulator_tb: errors");
            $finish;
        end
    end

    task automatic send(t_item it, bit gap);
        if (gap && $urandom_range(99) < 37) begin
            start <= 0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start <= 1;
        i_command <= it.cmd;
        i_time_step <= it.step;
        i_ex_sample <= it.smp[0];
        i_ey_sample <= it.smp[1];
        i_ez_sample <= it.smp[2];
        i_hx_sample <= it.smp[3];
        i_hy_sample <= it.smp[4];
        i_hz_sample <= it.smp[5];
        i_read_bin <= it.bin;
        i_read_component <= it.comp;
        do @(posedge i_clk); while (!(start && !busy));
        dft_predict(it);
    endtask

    task automatic cfg_write(logic [1:0] ix, logic [31:0] d);
        start <= 0;
        @(posedge i_clk);
        while (readout_q.size() != 0 || busy) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= ix;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 0;
        case (ix)
            REG_START: frq_start = d;
            REG_SPACING: frq_space = d;
            default: nbins_m1 = d[5:0];
        endcase
    endtask

    function automatic t_item mk_acc(logic [31:0] st, int v);
        t_item it;
        it.cmd = CMD_ACCUM;
        it.step = st;
        for (int c = 0; c < 6; c++) it.smp[c] = 16'(v);
        it.bin = 0;
        it.comp = 0;
        it.lit = 0;
        it.lit_re = 0;
        it.lit_im = 0;
        return it;
    endfunction

    function automatic t_item mk_rd(int b, int c, bit lit);
        t_item it;
        it = mk_acc($urandom, $urandom);
        it.cmd = CMD_READ;
        it.bin = 6'(b);
        it.comp = 3'(c);
        it.lit = lit;
        return it;
    endfunction

    function automatic t_item rnd_item();
        t_item it;
        int m;
        it = mk_rd($urandom_range(63), $urandom_range(7), 0);
        if ($urandom_range(99) < 55) it.cmd = CMD_ACCUM;
        for (int c = 0; c < 6; c++) begin
            m = $urandom_range(9);
            it.smp[c] = m == 0 ? 16'sh7fff : m == 1 ? 16'sh8000 : 16'($urandom);
        end
        return it;
    endfunction

    t_item dir_rows [$];
    logic [31:0] phase_start [5] = '{32'h0, 32'hffffffff, 32'h01234567, 32'h10000000, 32'h0};
    logic [31:0] phase_space [5] = '{32'hffffffff, 32'h0, 32'h00c0ffee, 32'h08000000, 32'h9e3779b9};
    logic [5:0] phase_bins [5] = '{6'd63, 6'd0, 6'd7, 6'd3, 6'd31};

    initial begin
        t_item it;
        build_wave();
        frq_start = 0;
        frq_space = 0;
        nbins_m1 = 0;
        foreach (sums[b, c, k]) sums[b][c][k] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        dir_rows = {dir_rows, mk_rd(0, 0, 1)};
        dir_rows = {dir_rows, mk_rd(63, 5, 1)};
        dir_rows = {dir_rows, mk_acc(32'h0, 32767)};
        dir_rows = {dir_rows, mk_acc(32'hffffffff, -32768)};
        dir_rows = {dir_rows, mk_acc(32'h5a5a5a5a, 1)};
        dir_rows = {dir_rows, mk_rd(0, 0, 0)};
        dir_rows = {dir_rows, mk_rd(0, 5, 0)};
        dir_rows = {dir_rows, mk_rd(1, 2, 0)};
        dir_rows = {dir_rows, mk_rd(5, 6, 1)};
        dir_rows = {dir_rows, mk_rd(0, 7, 1)};
        foreach (dir_rows[i]) send(dir_rows[i], 0);

        cfg_write(REG_START, 32'h00400000);
        cfg_write(REG_SPACING, 32'h00400000);
        cfg_write(REG_NBINS, 32'd63);
        for (int i = 0; i < 8; i++) begin
            it = mk_acc(32'(i), i[0] ? 32767 : -32768);
            send(it, 1);
        end
        for (int b = 0; b < 64; b += 9) send(mk_rd(b, b % 6, 0), 1);

        for (int p = 0; p < 5; p++) begin
            cfg_write(REG_START, phase_start[p]);
            cfg_write(REG_SPACING, phase_space[p]);
            cfg_write(REG_NBINS, 32'(phase_bins[p]));
            for (int i = 0; i < 380; i++) send(rnd_item(), !(p == 2 && i > 50));
        end

        start <= 0;
        while (readout_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("covered %0d accumulates and %0d reads over 7 register settings",
                 n_acc, n_rd);
        if (errors == 0) begin
            $display("point_running_dft_accumulator_tb: clean");
        end else begin
            $display("point_running_dft_accumulator_tb: errors");
        end
        $finish;
    end
endmodule
